FILE: rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} rsp_t;

	localparam logic FUNC_ABSORB = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	localparam int BLOCK_BYTES = 64;
	localparam int FIFO_DEPTH  = 4;

	// classified work item passed from front to back
	typedef struct packed {
		logic       finish;
		logic [7:0] data_byte;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_OUT
	} state_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_front.sv
`default_nettype none
module sha256_front
	import sha256_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire req_t in_req,
	output logic      cmd_valid,
	input  wire logic cmd_pop,
	output cmd_t      cmd
);

	localparam int PW = $clog2(FIFO_DEPTH);

	cmd_t          mem_q [FIFO_DEPTH];
	logic [PW:0]   wr_q;
	logic [PW:0]   rd_q;
	logic          push;

	// stall when the queue is full
	assign in_stall  = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (wr_q != rd_q);
	assign cmd       = mem_q[rd_q[PW-1:0]];

	// classify the request into a queue entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[PW-1:0]].finish    <= (in_req.func == FUNC_FINISH);
			mem_q[wr_q[PW-1:0]].data_byte <= in_req.data_byte;
		end
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (cmd_pop && cmd_valid)
				rd_q <= rd_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_back.sv
`default_nettype none
module sha256_back
	import sha256_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	input  wire cmd_t cmd,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      out_rsp
);

	state_t       state_q, state_d;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [31:0]  acc_q;
	logic [63:0]  cnt_q;
	logic [5:0]   pos_q;
	logic [5:0]   rnd_q;
	logic [3:0]   wcnt_q;
	logic         fin_q;
	logic         rsp_valid_q;
	rsp_t         rsp_q;
	logic [2:0]   oidx_q;

	// byte sink shared by absorb, padding and length
	logic        byte_we;
	logic [7:0]  byte_val;
	logic        go_comp;
	logic [63:0] bits;
	logic [2:0]  lsel;

	// round datapath
	logic [31:0] wt, m2, m15, sg0, sg1, t1, t2, s1e, s0a, ch, maj;

	assign bits = {cnt_q[60:0], 3'b000};
	assign lsel = pos_q[2:0];

	always_comb begin
		m2  = w_q[14];
		m15 = w_q[1];
		sg1 = rotr(m2, 17) ^ rotr(m2, 19) ^ (m2 >> 10);
		sg0 = rotr(m15, 7) ^ rotr(m15, 18) ^ (m15 >> 3);
		wt  = (rnd_q < 6'd16) ? w_q[0] : (sg1 + w_q[9] + sg0 + w_q[0]);
		s1e = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		s0a = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
		maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
		t1  = v_q[7] + s1e + ch + ROUND_K[rnd_q] + wt;
		t2  = s0a + maj;
	end

	// sequence control
	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		byte_we  = 1'b0;
		byte_val = cmd.data_byte;
		go_comp  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					byte_we = 1'b1;
					if (cmd.finish) begin
						byte_val = 8'h80;
						if (pos_q == 6'd63)
							go_comp = 1'b1;
						else if (pos_q >= 6'd56)
							state_d = ST_LEN;
						else
							state_d = ST_PAD;
					end else if (pos_q == 6'd63) begin
						go_comp = 1'b1;
					end
				end
				if (go_comp)
					state_d = ST_COMP;
			end
			ST_PAD: begin
				byte_we = 1'b1;
				byte_val = (pos_q >= 6'd56) ? bits[8'(63 - 8*lsel) -: 8] : 8'h00;
				if (pos_q == 6'd63) begin
					go_comp = 1'b1;
					state_d = ST_COMP;
				end
			end
			ST_LEN: begin
				// fill out a block with zeros, no length yet
				byte_we  = 1'b1;
				byte_val = 8'h00;
				if (pos_q == 6'd63) begin
					go_comp = 1'b1;
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				// branch after the last round
				if (rnd_q == 6'd63) begin
					if (!fin_q)
						state_d = ST_IDLE;
					else if (wcnt_q == 4'd1)
						state_d = ST_OUT;
					else
						state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if ((!rsp_valid_q || !out_stall) && oidx_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = rsp_valid_q;
	assign out_rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			wcnt_q      <= '0;
			fin_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			oidx_q      <= '0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= INIT_HASH[i];
		end else begin
			state_q <= state_d;
			if (byte_we) begin
				pos_q <= pos_q + 1'b1;
				if (state_q == ST_IDLE && !cmd.finish)
					cnt_q <= cnt_q + 1'b1;
				if (state_q == ST_IDLE)
					fin_q <= cmd.finish;
			end
			// mark the block that carries the length
			if (state_q == ST_PAD && go_comp)
				wcnt_q <= 4'd1;
			if (go_comp)
				rnd_q <= '0;
			// after the compression: fold the round result into the hash
			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == 6'd63) begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + ((i == 0) ? t1 + t2 :
							(i == 4) ? v_q[3] + t1 : v_q[i-1]);
					oidx_q <= '0;
				end
			end
			// drain the digest one word a cycle while the output is not stalled
			if (state_q == ST_OUT && (!rsp_valid_q || !out_stall)) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.digest_word <= h_q[oidx_q];
				rsp_q.word_index  <= oidx_q;
				rsp_q.last_word   <= (oidx_q == 3'd7);
				oidx_q            <= oidx_q + 1'b1;
				if (oidx_q == 3'd7) begin
					fin_q   <= 1'b0;
					wcnt_q  <= '0;
					cnt_q   <= '0;
					pos_q   <= '0;
					for (int i = 0; i < 8; i++)
						h_q[i] <= INIT_HASH[i];
				end
			end else if (!out_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// block buffer as words, schedule window shifts during rounds
	always_ff @(posedge clk) begin
		if (byte_we)
			acc_q <= {acc_q[23:0], byte_val};
		if (byte_we && pos_q[1:0] == 2'd3) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= {acc_q[23:0], byte_val};
		end
		if (go_comp) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
			for (int i = 1; i < 8; i++)
				v_q[i] <= v_q[i-1];
			v_q[4] <= v_q[3] + t1;
			v_q[0] <= t1 + t2;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_hash_engine_unit.sv
// SHA-256 byte-stream hashing engine.
// Request channel (in_valid/in_stall/in_req): func 0 absorbs data_byte,
// func 1 pads the message and returns its digest.
// Response channel (out_valid/out_stall/out_rsp): eight words per finish,
// word_index 0..7, last_word on the eighth.
// A four-entry request queue separates the front from the compression back
// end, so requests keep flowing while the back end works.
// Absorb: the back end takes one byte a cycle from the queue while idle; a full
// block then runs 64 rounds, one round a cycle through a single round unit.
// Finish: padding fills the block one byte a cycle; when the length does not
// fit, a second block of padding follows. One or two 64-round compressions
// follow, then eight words leave at one per cycle while out_stall is low.
// The back end takes no bytes during rounds; the queue holds requests meanwhile.
// Reset loads the standard initial hash and clears the byte count and queue.
// A stalled response holds its word; the back end waits and the queue
// then fills and stalls requests.
`default_nettype none
module sha256_hash_engine_unit
	import sha256_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire req_t in_req,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      out_rsp
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_req(in_req), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	sha256_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
		.cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
	);

endmodule
`default_nettype wire

FILE: rtl/core/sha256_checker.sv
`default_nettype none
module sha256_checker
	import sha256_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire rsp_t out_rsp
);

	// hold a stalled response
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_rsp))
		else $error("stalled response changed");

	// last word flag matches index
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.last_word == (out_rsp.word_index == 3'd7)))
		else $error("last_word mismatch");

	// words advance in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_rsp.last_word ##1 out_valid |->
		out_rsp.word_index == $past(out_rsp.word_index) + 3'd1)
		else $error("word order broken");

endmodule

bind sha256_hash_engine_unit sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_rsp(out_rsp)
);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
	import sha256_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_req;
	logic out_valid;
	logic out_stall;
	rsp_t out_rsp;

	sha256_hash_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp(out_rsp)
	);

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 600;

	// digest predictor state
	logic [31:0] hash_st [8];
	logic [7:0]  blk [64];
	logic [63:0] msg_bytes;

	req_t        pending_reqs [$];
	rsp_t        digest_fifo [$];
	int          errors;
	bit          stim_done;
	int          idle_cycles;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// run one block through the 64 rounds and fold into the hash
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int j = 0; j < 8; j++) v[j] = hash_st[j];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_K[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
			for (int j = 7; j > 0; j--) v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++) hash_st[j] = hash_st[j] + v[j];
	endtask

	task automatic hash_reset();
		for (int j = 0; j < 8; j++) hash_st[j] = INIT_HASH[j];
		msg_bytes = '0;
	endtask

	// absorb a byte or pad and queue the eight digest words
	task automatic predict(input req_t r);
		int pos;
		logic [63:0] bits;
		rsp_t d;
		pos = int'(msg_bytes[5:0]);
		if (r.func == FUNC_ABSORB) begin
			blk[pos] = r.data_byte;
			msg_bytes = msg_bytes + 1;
			if (pos == BLOCK_BYTES - 1) compress();
		end else begin
			blk[pos] = 8'h80;
			pos++;
			if (pos > BLOCK_BYTES - 8) begin
				while (pos < BLOCK_BYTES) blk[pos++] = 8'h00;
				compress();
				pos = 0;
			end
			while (pos < BLOCK_BYTES - 8) blk[pos++] = 8'h00;
			bits = msg_bytes << 3;
			for (int j = 0; j < 8; j++) blk[56+j] = bits[63-8*j -: 8];
			compress();
			for (int j = 0; j < 8; j++) begin
				d.digest_word = hash_st[j];
				d.word_index = 3'(j);
				d.last_word = (j == 7);
				digest_fifo.push_back(d);
			end
			hash_reset();
		end
	endtask

	task automatic add_msg(input int n);
		req_t r;
		for (int i = 0; i < n; i++) begin
			r.func = FUNC_ABSORB;
			r.data_byte = 8'($urandom_range(0, 255));
			pending_reqs.push_back(r);
		end
		r.func = FUNC_FINISH;
		r.data_byte = 8'($urandom_range(0, 255));
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stimulus: directed messages, then random ones
	initial begin
		req_t r;
		int total;
		errors = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		hash_reset();
		// empty message, byte extremes, length boundary cases
		add_msg(0);
		r.func = FUNC_ABSORB;
		r.data_byte = 8'h00;
		pending_reqs.push_back(r);
		r.data_byte = 8'hff;
		pending_reqs.push_back(r);
		r.func = FUNC_FINISH;
		r.data_byte = 8'hff;
		pending_reqs.push_back(r);
		total = 3;
		while (total < 230) begin
			case ($urandom_range(0, 5))
				0: add_msg(55);
				1: add_msg(56);
				2: add_msg(63);
				3: add_msg(64);
				default: add_msg($urandom_range(0, 20));
			endcase
			total = pending_reqs.size();
		end
		add_msg(130);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		stim_done = 1'b1;
	end

	// drive requests with random gaps
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req <= '0;
			gap_cnt = $urandom_range(0, 18);
		end else begin
			if (in_valid && !in_stall) begin
				predict(in_req);
				void'(pending_reqs.pop_front());
				gap_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_cnt > 0 || pending_reqs.size() == 0 || (in_valid && !in_stall
					&& pending_reqs.size() == 0)) begin
					if (gap_cnt > 0) gap_cnt--;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_req <= pending_reqs[0];
				end
			end
		end
	end

	// receive digest words, with random stalls and one long hold
	int stall_cnt;
	int hold_cnt;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			stall_cnt = 0;
			hold_cnt = 0;
			hold_done = 1'b0;
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (in_valid && !in_stall) idle_cycles = 0;
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (digest_fifo.size() == 0) begin
					$display("%0t: unexpected digest word %h", $time, out_rsp);
					errors++;
				end else begin
					if (out_rsp !== digest_fifo[0]) begin
						$display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
							$time, digest_fifo[0].digest_word, digest_fifo[0].word_index,
							digest_fifo[0].last_word, out_rsp.digest_word,
							out_rsp.word_index, out_rsp.last_word);
						errors++;
					end
					void'(digest_fifo.pop_front());
				end
				stall_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			end
			if (!hold_done && digest_fifo.size() >= 16) begin
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// end of run and watchdog
	initial begin
		wait (arst_n);
		while (!(stim_done && digest_fifo.size() == 0) && idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: done, errors");
		end else begin
			repeat (300) @(posedge clk);
			if (errors == 0)
				$display("tb: done, clean");
			else
				$display("tb: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
